>>> sv/ids_pkg.sv
package ids_pkg;

   localparam int DATA_W    = 32;
   localparam int OP_W      = 4;
   localparam int POS_W     = 6;
   localparam int ST_W      = 2;
   localparam int CNT_OUT_W = 7;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
   localparam logic [OP_W-1:0] OP_REMOVE     = 4'd4;
   localparam logic [OP_W-1:0] OP_READ       = 4'd5;
   localparam logic [OP_W-1:0] OP_INSERT     = 4'd6;
   localparam logic [OP_W-1:0] OP_WRITE      = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;
   localparam logic [OP_W-1:0] OP_QUERY      = 4'd9;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_SHIFT = 4'b0100,
      S_FILL  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0]    read_value;
      logic [ST_W-1:0]      status;
      logic [CNT_OUT_W-1:0] count;
      logic                 is_empty;
   } result_type;

endpackage

>>> sv/ids_if.sv
interface ids_req_if;
   logic                               valid;
   logic                               ready;
   logic [ids_pkg::OP_W-1:0]           operation;
   logic [ids_pkg::POS_W-1:0]          position;
   logic signed [ids_pkg::DATA_W-1:0]  value;

   modport source (output valid, operation, position, value, input ready);
   modport sink   (input valid, operation, position, value, output ready);
endinterface

interface ids_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ids_pkg::DATA_W-1:0]  read_value;
   logic [ids_pkg::ST_W-1:0]           status;
   logic [ids_pkg::CNT_OUT_W-1:0]      count;
   logic                               is_empty;

   modport source (output valid, read_value, status, count, is_empty, input ready);
   modport sink   (input valid, read_value, status, count, is_empty, output ready);
endinterface

>>> sv/ids_ram.sv
module ids_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [ids_pkg::DATA_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [ids_pkg::DATA_W-1:0] rd_data
);
   import ids_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/indexed_sequence_store.sv
// channel  | dir | handshake          | payload
// req_ch   | in  | valid/ready        | operation, position, value
// rsp_ch   | out | valid/ready        | read_value, status, count, is_empty
//
// One request at a time. Single-element requests form their result in the accept cycle
// (read: in the next cycle), then pass the pending slot and output register to rsp_ch.
// Insert and push front shift then fill the gap; remove and pop front only shift (not
// at all if nothing moves). Elements move one per cycle through the element memory's
// read and write ports. Reset clears count, state and valid flags, not the memory.
// ready is low the cycle after a result is formed and while a second result waits.
module indexed_sequence_store #(
   parameter int CAPACITY = 64
) (
   input logic        clock,
   input logic        reset,
   ids_req_if.sink    req_ch,
   ids_rsp_if.source  rsp_ch
);
   import ids_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [AW-1:0] ONE_A = AW'(1);

   state_type         state_ff, state_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     left_ff, left_in;
   logic              down_ff, down_in;
   logic [AW-1:0]     fill_addr_ff, fill_addr_in;
   logic [DATA_W-1:0] fill_val_ff, fill_val_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;

   logic              req_fire, move;
   logic              full, empty, idx_bad;
   logic [LW-1:0]     cnt_l, pos_l, cnt_out_l;
   logic [CW-1:0]     pos_c, go_pos, moves;
   logic [CW-1:0]     cnt_dec, go_inc;
   logic [AW-1:0]     pos_a;
   logic              load, ins_go, rem_go;
   logic [ST_W-1:0]   status_v;
   logic [DATA_W-1:0] rd_v;

   ids_ram #(.DEPTH(CAPACITY), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && !pend_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign cnt_l   = LW'(cnt_ff);
   assign pos_l   = LW'(req_ch.position);
   assign pos_c   = pos_l[CW-1:0];
   assign pos_a   = pos_l[AW-1:0];
   assign full    = (cnt_ff == CAP_C);
   assign empty   = (cnt_ff == '0);
   assign idx_bad = (pos_l >= cnt_l);
   assign moves   = cnt_ff - go_pos - ONE_C;
   assign cnt_dec = cnt_ff - ONE_C;
   assign go_inc  = go_pos + ONE_C;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      down_in      = down_ff;
      fill_addr_in = fill_addr_ff;
      fill_val_in  = fill_val_ff;
      wr_valid_in  = 1'b0;
      wr_addr_in   = wr_addr_ff;
      ram_we       = 1'b0;
      ram_waddr    = wr_addr_ff;
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = ptr_ff;
      load         = 1'b0;
      ins_go       = 1'b0;
      rem_go       = 1'b0;
      go_pos       = '0;
      status_v     = ST_OK;
      rd_v         = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               load = 1'b1;
               case (req_ch.operation)
                  OP_PUSH_BACK: begin
                     if (full) begin
                        status_v = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cnt_ff[AW-1:0];
                        ram_wdata = req_ch.value;
                        cnt_in    = cnt_ff + ONE_C;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (full) begin
                        status_v = ST_FULL;
                     end else if (empty) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = req_ch.value;
                        cnt_in    = ONE_C;
                     end else begin
                        ins_go = 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (empty) begin
                        status_v = ST_EMPTY;
                     end else begin
                        cnt_in = cnt_ff - ONE_C;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (empty) begin
                        status_v = ST_EMPTY;
                     end else begin
                        rem_go = 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (idx_bad) begin
                        status_v = ST_INDEX;
                     end else begin
                        rem_go = 1'b1;
                        go_pos = pos_c;
                     end
                  end
                  OP_READ: begin
                     if (idx_bad) begin
                        status_v = ST_INDEX;
                     end else begin
                        load      = 1'b0;
                        ram_re    = 1'b1;
                        ram_raddr = pos_a;
                        state_in  = S_READ;
                     end
                  end
                  OP_INSERT: begin
                     if (idx_bad) begin
                        status_v = ST_INDEX;
                     end else if (full) begin
                        status_v = ST_FULL;
                     end else begin
                        ins_go = 1'b1;
                        go_pos = pos_c;
                     end
                  end
                  OP_WRITE: begin
                     if (idx_bad) begin
                        status_v = ST_INDEX;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = pos_a;
                        ram_wdata = req_ch.value;
                     end
                  end
                  OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase

               // insert: shift [go_pos, cnt) up by one, top down, then fill the gap
               if (ins_go) begin
                  load         = 1'b0;
                  state_in     = S_SHIFT;
                  ptr_in       = cnt_dec[AW-1:0];
                  left_in      = cnt_ff - go_pos;
                  down_in      = 1'b1;
                  fill_addr_in = go_pos[AW-1:0];
                  fill_val_in  = req_ch.value;
                  cnt_in       = cnt_ff + ONE_C;
               end

               // remove: shift (go_pos, cnt) down by one, bottom up
               if (rem_go) begin
                  cnt_in  = cnt_ff - ONE_C;
                  ptr_in  = go_inc[AW-1:0];
                  left_in = moves;
                  down_in = 1'b0;
                  if (moves != '0) begin
                     load     = 1'b0;
                     state_in = S_SHIFT;
                  end
               end
            end
         end
         S_READ: begin
            load     = 1'b1;
            rd_v     = ram_rdata;
            state_in = S_IDLE;
         end
         S_SHIFT: begin
            // read of one element overlaps the write-back of the previous one
            if (wr_valid_ff) begin
               ram_we = 1'b1;
            end
            if (left_ff != '0) begin
               ram_re      = 1'b1;
               ptr_in      = down_ff ? ptr_ff - ONE_A : ptr_ff + ONE_A;
               left_in     = left_ff - ONE_C;
               wr_valid_in = 1'b1;
               wr_addr_in  = down_ff ? ptr_ff + ONE_A : ptr_ff - ONE_A;
            end else if (down_ff) begin
               state_in = S_FILL;
            end else begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = fill_addr_ff;
            ram_wdata = fill_val_ff;
            load      = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_out_l = LW'(cnt_in);

   always_comb begin
      pend_in            = pend_ff;
      pend_in.read_value = rd_v;
      pend_in.status     = status_v;
      pend_in.count      = cnt_out_l[CNT_OUT_W-1:0];
      pend_in.is_empty   = (cnt_in == '0);
      if (!load) begin
         pend_in = pend_ff;
      end
   end

   // two-entry result queue: pending slot feeds the output register
   assign move          = pend_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign pend_valid_in = load ? 1'b1 : (move ? 1'b0 : pend_valid_ff);
   assign rsp_valid_in  = move ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign rsp_in        = move ? pend_ff : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         wr_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         wr_valid_ff   <= wr_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      left_ff      <= left_in;
      down_ff      <= down_in;
      fill_addr_ff <= fill_addr_in;
      fill_val_ff  <= fill_val_in;
      wr_addr_ff   <= wr_addr_in;
      pend_ff      <= pend_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.read_value = rsp_ff.read_value;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.count      = rsp_ff.count;
   assign rsp_ch.is_empty   = rsp_ff.is_empty;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CAP_C)
      else $error("element count above capacity");

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pend_valid_ff || state_ff != S_IDLE))
      else $error("accepted request left no trace");

   a_shift_addr: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> (CW'(wr_addr_ff) < cnt_ff))
      else $error("shift write outside stored range");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == S_IDLE))
      else $error("pending result while a request is in flight");

endmodule

>>> verif/indexed_sequence_store_tb.sv
module indexed_sequence_store_tb;
   import ids_pkg::*;

   localparam int CAPACITY     = 64;
   localparam int RANDOM_ITEMS = 1100;
   localparam int LONG_HOLD    = 400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 80;

   // codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd10;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;

   typedef enum logic [1:0] {GROW, SHRINK, MIXED} episode_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      logic              given;
      result_type        given_rsp;
   } step_type;

   logic clock;
   logic reset;

   ids_req_if req_ch ();
   ids_rsp_if rsp_ch ();

   indexed_sequence_store #(.CAPACITY(CAPACITY)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic signed [DATA_W-1:0] shadow_list [$];
   result_type               awaited_responses [$];

   int mismatches    = 0;
   int burst_left    = 0;
   int idle_cycles   = 0;
   int hold_left     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   logic [7:0] ready_mask = 8'hff;
   logic [5:0] mask_age   = '0;

   step_type directed_steps [25] = '{
      '{OP_QUERY,      6'd0,  32'd0,         1'b1, '{32'd0, ST_OK,    7'd0, 1'b1}},
      '{OP_POP_BACK,   6'd0,  32'd0,         1'b1, '{32'd0, ST_EMPTY, 7'd0, 1'b1}},
      '{OP_POP_FRONT,  6'd0,  32'd0,         1'b1, '{32'd0, ST_EMPTY, 7'd0, 1'b1}},
      '{OP_READ,       6'd0,  32'd0,         1'b1, '{32'd0, ST_INDEX, 7'd0, 1'b1}},
      '{OP_REMOVE,     6'd63, 32'd0,         1'b1, '{32'd0, ST_INDEX, 7'd0, 1'b1}},
      '{OP_INSERT,     6'd0,  32'd1234,      1'b1, '{32'd0, ST_INDEX, 7'd0, 1'b1}},
      '{OP_WRITE,      6'd0,  32'hffff_ffff, 1'b1, '{32'd0, ST_INDEX, 7'd0, 1'b1}},
      '{OP_CLEAR,      6'd0,  32'd0,         1'b1, '{32'd0, ST_OK,    7'd0, 1'b1}},
      '{OP_SPARE_HI,   6'd63, 32'hffff_ffff, 1'b1, '{32'd0, ST_OK,    7'd0, 1'b1}},
      '{OP_PUSH_BACK,  6'd0,  32'h7fff_ffff, 1'b1, '{32'd0, ST_OK,    7'd1, 1'b0}},
      '{OP_PUSH_FRONT, 6'd0,  32'h8000_0000, 1'b1, '{32'd0, ST_OK,    7'd2, 1'b0}},
      '{OP_READ,       6'd0,  32'd0,  1'b1, '{32'h8000_0000, ST_OK, 7'd2, 1'b0}},
      '{OP_READ,       6'd1,  32'd0,  1'b1, '{32'h7fff_ffff, ST_OK, 7'd2, 1'b0}},
      // insert at the count is out of range
      '{OP_INSERT,     6'd2,  32'd5,         1'b1, '{32'd0, ST_INDEX, 7'd2, 1'b0}},
      '{OP_INSERT,     6'd1,  32'hffff_ffff, 1'b0, '0},
      '{OP_INSERT,     6'd0,  32'd0,         1'b0, '0},
      '{OP_WRITE,      6'd3,  32'ha5a5_a5a5, 1'b0, '0},
      '{OP_READ,       6'd3,  32'd0,         1'b0, '0},
      '{OP_READ,       6'd63, 32'd0,         1'b1, '{32'd0, ST_INDEX, 7'd4, 1'b0}},
      '{OP_REMOVE,     6'd1,  32'd0,         1'b0, '0},
      '{OP_SPARE_LO,   6'd0,  32'd0,         1'b0, '0},
      '{OP_POP_FRONT,  6'd0,  32'd0,         1'b0, '0},
      '{OP_POP_BACK,   6'd0,  32'd0,         1'b0, '0},
      '{OP_QUERY,      6'd0,  32'd0,         1'b0, '0},
      '{OP_CLEAR,      6'd0,  32'd0,         1'b1, '{32'd0, ST_OK,    7'd0, 1'b1}}
   };

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic result_type list_op_outcome(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                  logic signed [DATA_W-1:0] val);
      result_type  r;
      int unsigned n;
      n = shadow_list.size();
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_PUSH_BACK: begin
            if (n >= CAPACITY) r.status = ST_FULL;
            else shadow_list.insert(n, val);
         end
         OP_PUSH_FRONT: begin
            if (n >= CAPACITY) r.status = ST_FULL;
            else shadow_list.insert(0, val);
         end
         OP_POP_BACK: begin
            if (n == 0) r.status = ST_EMPTY;
            else shadow_list.delete(n - 1);
         end
         OP_POP_FRONT: begin
            if (n == 0) r.status = ST_EMPTY;
            else shadow_list.delete(0);
         end
         OP_REMOVE: begin
            if (pos >= n) r.status = ST_INDEX;
            else shadow_list.delete(pos);
         end
         OP_READ: begin
            if (pos >= n) r.status = ST_INDEX;
            else r.read_value = shadow_list[pos];
         end
         OP_INSERT: begin
            // range check wins over the full check
            if (pos >= n) r.status = ST_INDEX;
            else if (n >= CAPACITY) r.status = ST_FULL;
            else shadow_list.insert(pos, val);
         end
         OP_WRITE: begin
            if (pos >= n) r.status = ST_INDEX;
            else shadow_list[pos] = val;
         end
         OP_CLEAR: shadow_list.delete();
         default: ;
      endcase
      r.count    = CNT_OUT_W'(shadow_list.size());
      r.is_empty = (shadow_list.size() == 0);
      return r;
   endfunction

   task automatic offer_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] val, input logic given,
                                input result_type given_rsp);
      int         gap;
      result_type outcome;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(3) != 0) gap = $urandom_range(1, 12);
      end
      burst_left--;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.position  <= pos;
      req_ch.value     <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      outcome = list_op_outcome(op, pos, val);
      awaited_responses.insert(awaited_responses.size(), given ? given_rsp : outcome);
   endtask

   task automatic pick_request(input episode_type kind, output logic [OP_W-1:0] op,
                               output logic [POS_W-1:0] pos, output logic [DATA_W-1:0] val);
      int unsigned r;
      int unsigned n;
      n = shadow_list.size();
      r = $urandom_range(99);
      case (kind)
         GROW: begin
            if (r < 30) op = OP_PUSH_BACK;
            else if (r < 50) op = OP_PUSH_FRONT;
            else if (r < 75) op = OP_INSERT;
            else if (r < 82) op = OP_WRITE;
            else if (r < 92) op = OP_READ;
            else op = OP_W'($urandom_range(15));
         end
         SHRINK: begin
            if (r < 22) op = OP_POP_BACK;
            else if (r < 44) op = OP_POP_FRONT;
            else if (r < 70) op = OP_REMOVE;
            else if (r < 80) op = OP_READ;
            else if (r < 88) op = OP_WRITE;
            else op = OP_W'($urandom_range(15));
         end
         default: begin
            if (r < 12) op = OP_PUSH_BACK;
            else if (r < 24) op = OP_PUSH_FRONT;
            else if (r < 34) op = OP_POP_BACK;
            else if (r < 44) op = OP_POP_FRONT;
            else if (r < 54) op = OP_REMOVE;
            else if (r < 66) op = OP_READ;
            else if (r < 78) op = OP_INSERT;
            else if (r < 90) op = OP_WRITE;
            else if (r < 93) op = OP_CLEAR;
            else if (r < 96) op = OP_QUERY;
            else op = OP_W'($urandom_range(15));
         end
      endcase
      r = $urandom_range(9);
      if (n != 0 && r < 8) pos = POS_W'($urandom_range(n - 1));
      else if (r == 8) pos = POS_W'(n);
      else pos = POS_W'($urandom);
      case ($urandom_range(15))
         0: val = 32'h8000_0000;
         1: val = 32'h7fff_ffff;
         default: val = $urandom;
      endcase
   endtask

   initial begin
      episode_type       kind;
      int                rand_done;
      int                ep_len;
      int                tail;
      logic [OP_W-1:0]   op;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.operation <= '0;
      req_ch.position  <= '0;
      req_ch.value     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         offer_request(directed_steps[i].op, directed_steps[i].pos, directed_steps[i].val,
                       directed_steps[i].given, directed_steps[i].given_rsp);

      // first episode fills the list so the full cases come early
      kind      = GROW;
      rand_done = 0;
      while (rand_done < RANDOM_ITEMS) begin
         ep_len = 0;
         tail   = -1;
         while (ep_len < 200 && tail != 0 && rand_done < RANDOM_ITEMS) begin
            pick_request(kind, op, pos, val);
            offer_request(op, pos, val, 1'b0, '0);
            rand_done++;
            ep_len++;
            if (rand_done == 300 || rand_done == 750) hold_requests++;
            if (tail > 0) tail--;
            else if (kind == GROW && shadow_list.size() == CAPACITY) tail = 12;
            else if (kind == SHRINK && shadow_list.size() == 0) tail = 6;
            else if (kind == MIXED && ep_len == 40) tail = 0;
         end
         kind = episode_type'($urandom_range(2));
      end
      req_ch.valid <= 1'b0;

      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("indexed_sequence_store regression: pass");
      else $display("indexed_sequence_store regression: fail");
      $finish;
   end

   // response side: long holds on request, otherwise a rotating stall mask
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left--;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (mask_age == 0) begin
            case ($urandom_range(3))
               0: ready_mask = 8'hff;
               1: ready_mask = 8'h0f;
               2: ready_mask = 8'b1011_0110;
               default: ready_mask = 8'($urandom);
            endcase
            if (ready_mask == 0) ready_mask = 8'h01;
         end
         rsp_ch.ready <= ready_mask[mask_age[2:0]];
         mask_age++;
      end
   end

   always @(posedge clock) begin : check_rsp
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_responses.size() == 0) begin
            $error("response with no request outstanding: read_value %h status %0d count %0d",
                   rsp_ch.read_value, rsp_ch.status, rsp_ch.count);
            mismatches++;
         end else begin
            want = awaited_responses[0];
            awaited_responses.delete(0);
            if (rsp_ch.read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_ch.read_value);
               mismatches++;
            end
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
               mismatches++;
            end
            if (rsp_ch.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
               mismatches++;
            end
            if (rsp_ch.is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_ch.is_empty);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("indexed_sequence_store regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
